// File: sv/wc_pkg.sv
// Shared widths, sizes and control types of the weighted centroid block.
`default_nettype none

package wc_pkg;

    // Field and register widths
    localparam int MASS_W    = 16;
    localparam int LEN_W     = 11;
    localparam int CENT_W    = 18;
    localparam int TOTAL_W   = 36;

    // Accumulator widths
    localparam int MSUM_W    = 37;
    localparam int WSUM_W    = 56;

    // Matrix size limits and centroid format
    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int FRAC_BITS = 8;

    // Derived sizes
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CENT_INT  = CENT_W - FRAC_BITS;
    localparam int CNT_W     = $clog2(CENT_W + 1);

    localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(4);

    // Step controls from the sequencer to the accumulator
    typedef struct packed {
        logic mul;
        logic add;
        logic clear;
    } acc_ctl_t;

endpackage

`default_nettype wire

// File: sv/wc_accum.sv
// Accumulator: element position, weight products and saturating moment sums.
`default_nettype none

module wc_accum (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wc_pkg::acc_ctl_t           ctl,
    input  logic [wc_pkg::MASS_W-1:0]  mass,
    input  logic [wc_pkg::LEN_W-1:0]   row_length,
    output logic [wc_pkg::MSUM_W-1:0]  mass_sum,
    output logic [wc_pkg::WSUM_W-1:0]  row_wsum,
    output logic [wc_pkg::WSUM_W-1:0]  col_wsum
);
    import wc_pkg::*;

    localparam int CLEN_W  = $clog2(MAX_COLS + 1);
    localparam int CMP_W   = (LEN_W > CLEN_W) ? LEN_W : CLEN_W;
    localparam int CPROD_W = COL_W + MASS_W;
    localparam int RPROD_W = ROW_W + MASS_W;

    logic [COL_W-1:0]   col_idx_reg,   col_idx_next;
    logic [ROW_W-1:0]   row_idx_reg,   row_idx_next;
    logic [CPROD_W-1:0] col_prod_reg,  col_prod_next;
    logic [RPROD_W-1:0] row_prod_reg,  row_prod_next;
    logic [MSUM_W-1:0]  mass_sum_reg,  mass_sum_next;
    logic [WSUM_W-1:0]  row_wsum_reg,  row_wsum_next;
    logic [WSUM_W-1:0]  col_wsum_reg,  col_wsum_next;

    logic [CMP_W-1:0]   len_ext;
    logic [CMP_W-1:0]   len_eff;
    logic [CMP_W-1:0]   col_inc;
    logic               row_end;
    logic [MSUM_W:0]    msum_wide;
    logic [WSUM_W:0]    rsum_wide;
    logic [WSUM_W:0]    csum_wide;

    // Clip the row length to one through the column limit
    always_comb
    begin
        len_ext = CMP_W'(row_length);
        if (len_ext == '0)
        begin
            len_eff = CMP_W'(1);
        end
        else if (len_ext > CMP_W'(MAX_COLS))
        begin
            len_eff = CMP_W'(MAX_COLS);
        end
        else
        begin
            len_eff = len_ext;
        end
        col_inc = CMP_W'(col_idx_reg) + CMP_W'(1);
        row_end = (col_inc >= len_eff);
    end

    // Add with one spare bit; a carry out means the sum hit its ceiling
    always_comb
    begin
        msum_wide = {1'b0, mass_sum_reg} + (MSUM_W + 1)'(mass);
        rsum_wide = {1'b0, row_wsum_reg} + (WSUM_W + 1)'(row_prod_reg);
        csum_wide = {1'b0, col_wsum_reg} + (WSUM_W + 1)'(col_prod_reg);
    end

    // Step the products, the sums and the position
    always_comb
    begin
        col_idx_next  = col_idx_reg;
        row_idx_next  = row_idx_reg;
        col_prod_next = col_prod_reg;
        row_prod_next = row_prod_reg;
        mass_sum_next = mass_sum_reg;
        row_wsum_next = row_wsum_reg;
        col_wsum_next = col_wsum_reg;

        if (ctl.mul)
        begin
            col_prod_next = CPROD_W'(col_idx_reg) * CPROD_W'(mass);
            row_prod_next = RPROD_W'(row_idx_reg) * RPROD_W'(mass);
        end

        if (ctl.clear)
        begin
            col_idx_next  = '0;
            row_idx_next  = '0;
            mass_sum_next = '0;
            row_wsum_next = '0;
            col_wsum_next = '0;
        end
        else if (ctl.add)
        begin
            mass_sum_next = msum_wide[MSUM_W] ? '1 : msum_wide[MSUM_W-1:0];
            row_wsum_next = rsum_wide[WSUM_W] ? '1 : rsum_wide[WSUM_W-1:0];
            col_wsum_next = csum_wide[WSUM_W] ? '1 : csum_wide[WSUM_W-1:0];
            if (row_end)
            begin
                col_idx_next = '0;
                // Hold the row index at the last row
                if (row_idx_reg != ROW_W'(MAX_ROWS - 1))
                begin
                    row_idx_next = row_idx_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_idx_next = col_idx_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_idx_reg  <= '0;
            row_idx_reg  <= '0;
            mass_sum_reg <= '0;
            row_wsum_reg <= '0;
            col_wsum_reg <= '0;
        end
        else
        begin
            col_idx_reg  <= col_idx_next;
            row_idx_reg  <= row_idx_next;
            mass_sum_reg <= mass_sum_next;
            row_wsum_reg <= row_wsum_next;
            col_wsum_reg <= col_wsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_prod_reg <= col_prod_next;
        row_prod_reg <= row_prod_next;
    end

    assign mass_sum = mass_sum_reg;
    assign row_wsum = row_wsum_reg;
    assign col_wsum = col_wsum_reg;

endmodule

`default_nettype wire

// File: sv/wc_div.sv
// Shared restoring divider: saturated fixed-point quotient, one bit per cycle.
`default_nettype none

module wc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wc_pkg::WSUM_W-1:0]  dividend,
    input  logic [wc_pkg::MSUM_W-1:0]  divisor,
    output logic                       done,
    output logic [wc_pkg::CENT_W-1:0]  quotient
);
    import wc_pkg::*;

    localparam int SHIFT_W = MSUM_W + CENT_INT;
    localparam int OVF_W   = (WSUM_W > SHIFT_W) ? WSUM_W : SHIFT_W;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [MSUM_W-1:0]  rem_reg,  rem_next;
    logic [CENT_W-1:0]  shf_reg,  shf_next;
    logic [CENT_W-1:0]  quo_reg,  quo_next;

    logic               ovf;
    logic [MSUM_W-1:0]  rem_init;
    logic [CENT_W-1:0]  shf_init;
    logic [MSUM_W:0]    trial;
    logic [MSUM_W:0]    diff;
    logic               fits;

    // Quotient needs more than the centroid width when dividend >= divisor << int bits
    always_comb
    begin
        ovf      = (OVF_W'(dividend) >= (OVF_W'(divisor) << CENT_INT));
        rem_init = MSUM_W'(dividend >> CENT_INT);
        shf_init = CENT_W'(dividend[CENT_INT-1:0]) << FRAC_BITS;
        trial    = {rem_reg, shf_reg[CENT_W-1]};
        diff     = trial - {1'b0, divisor};
        fits     = (trial >= {1'b0, divisor});
    end

    // Divisor is held steady by the caller for the whole pass
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            if (ovf)
            begin
                quo_next  = '1;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = CNT_W'(CENT_W);
                rem_next  = rem_init;
                shf_next  = shf_init;
                quo_next  = '0;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[MSUM_W-1:0] : trial[MSUM_W-1:0];
            shf_next = shf_reg << 1;
            quo_next = {quo_reg[CENT_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: sv/weighted_centroid_top.sv
// Weighted centroid top: request sequencer, accumulator, shared divider, output register.
// An element passes accept, product and sum states; the next one is accepted right after.
// After the last element the divider runs row then column, each a start then 18 quotient bits,
// and the result loads once the output is free (sooner on zero mass or a saturated quotient);
// input stalls until then. Reset clears sums, position, sequencer and output valid;
// row_length resets to 4.
`default_nettype none

module weighted_centroid_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [wc_pkg::LEN_W-1:0]   cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [wc_pkg::MASS_W-1:0]  mass_value,
    input  logic                       last_element,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [wc_pkg::CENT_W-1:0]  row_centroid,
    output logic [wc_pkg::CENT_W-1:0]  col_centroid,
    output logic [wc_pkg::TOTAL_W-1:0] total_mass,
    output logic                       zero_mass
);
    import wc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_MUL      = 8'b0000_0010,
        ST_ADD      = 8'b0000_0100,
        ST_ROW_GO   = 8'b0000_1000,
        ST_ROW_WAIT = 8'b0001_0000,
        ST_COL_GO   = 8'b0010_0000,
        ST_COL_WAIT = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    row_length_reg;
    logic [MASS_W-1:0]   mass_reg;
    logic                last_reg;
    logic [CENT_W-1:0]   row_res_reg;
    logic [CENT_W-1:0]   col_res_reg;
    logic                out_valid_reg, out_valid_next;
    logic [CENT_W-1:0]   row_out_reg;
    logic [CENT_W-1:0]   col_out_reg;
    logic [TOTAL_W-1:0]  total_out_reg;
    logic                zero_out_reg;

    acc_ctl_t            acc_ctl;
    logic [MSUM_W-1:0]   mass_sum;
    logic [WSUM_W-1:0]   row_wsum;
    logic [WSUM_W-1:0]   col_wsum;

    logic                div_start;
    logic                col_sel;
    logic                div_done;
    logic [CENT_W-1:0]   div_quo;
    logic [WSUM_W-1:0]   div_dividend;

    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                sum_zero;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign sum_zero  = (mass_sum == '0);

    wc_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (acc_ctl),
        .mass       (mass_reg),
        .row_length (row_length_reg),
        .mass_sum   (mass_sum),
        .row_wsum   (row_wsum),
        .col_wsum   (col_wsum)
    );

    assign div_dividend = col_sel ? col_wsum : row_wsum;

    wc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (mass_sum),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequence a request through accumulate; after the last, both divisions or none on zero mass
    always_comb
    begin
        state_next = state_reg;
        acc_ctl    = '0;
        div_start  = 1'b0;
        col_sel    = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_ctl.mul = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD:
            begin
                acc_ctl.add = 1'b1;
                state_next  = last_reg ? ST_ROW_GO : ST_IDLE;
            end
            ST_ROW_GO:
            begin
                // Skip both divisions on zero mass
                if (sum_zero)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_ROW_WAIT;
                end
            end
            ST_ROW_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_COL_GO;
                end
            end
            ST_COL_GO:
            begin
                div_start  = 1'b1;
                col_sel    = 1'b1;
                state_next = ST_COL_WAIT;
            end
            ST_COL_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Wait for room in the output register, then clear for the next matrix
                if (out_free)
                begin
                    out_load      = 1'b1;
                    acc_ctl.clear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Keep the output valid until taken
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_length_reg <= ROW_LENGTH_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                row_length_reg <= cfg_wdata;
            end
        end
    end

    // Latch the request, the quotients and the result
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mass_reg <= mass_value;
            last_reg <= last_element;
        end
        if (div_done && (state_reg == ST_ROW_WAIT))
        begin
            row_res_reg <= div_quo;
        end
        if (div_done && (state_reg == ST_COL_WAIT))
        begin
            col_res_reg <= div_quo;
        end
        if (out_load)
        begin
            zero_out_reg  <= sum_zero;
            row_out_reg   <= sum_zero ? '0 : row_res_reg;
            col_out_reg   <= sum_zero ? '0 : col_res_reg;
            total_out_reg <= (mass_sum[MSUM_W-1:TOTAL_W] != '0) ? '1
                                                                : mass_sum[TOTAL_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_centroid = row_out_reg;
    assign col_centroid = col_out_reg;
    assign total_mass   = total_out_reg;
    assign zero_mass    = zero_out_reg;

    // Divider finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_ROW_WAIT || state_reg == ST_COL_WAIT))
        else $error("divider done outside a wait state");

    // Never divide by a zero total
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (mass_sum != '0))
        else $error("division started with zero mass");

    // Zero mass result carries zero centroids and total
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_mass) |->
            (row_centroid == '0 && col_centroid == '0 && total_mass == '0))
        else $error("zero mass result with nonzero fields");

endmodule

`default_nettype wire
